// ===== src/assert_macros.svh =====
// Assertion macros shared by the tone curve modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PLTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/pltc_pkg.sv =====
// Package: types, constants and codes of the piecewise-linear tone curve.
`timescale 1ns / 1ps
package pltc_pkg;

  localparam int MaxPoints = 32;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam int NumW      = 34;
  localparam int DenW      = 26;
  localparam int QuoW      = 17;
  localparam int DivCntW   = $clog2(QuoW);

  localparam logic OpLoad = 1'b0;
  localparam logic OpMap  = 1'b1;

  localparam logic [1:0] CfgPointCount = 2'd0;
  localparam logic [1:0] CfgInvert     = 2'd1;
  localparam logic [1:0] CfgSampleMode = 2'd2;

  typedef struct packed {
    logic        op;
    logic [4:0]  point_index;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [15:0] mapped_pixel;
    logic [5:0]  segment;
  } out_word_t;

  typedef struct packed {
    logic [5:0] point_count;
    logic       invert;
    logic       sample_mode;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    SIdle,
    SLdWrite,
    SPxLast,
    SPxFirst,
    SScan,
    SMul0,
    SMul1,
    SSum,
    SDivWait,
    SDone
  } seq_state_e;

endpackage

// ===== src/piecewise_linear_tone_curve_top.sv =====
// A load word is written to the RAM in SLdWrite; a pixel word above the last breakpoint
// goes straight to the multiplier, else the first breakpoint is read and, if needed, a scan.
// Throughput: one word at a time; the search reads one breakpoint per cycle from the
// breakpoint RAM, then a radix-2 divider finishes the interpolation.
// Reset: async active low clears control and sets point_count 7, invert 0,
// sample_mode 0; breakpoint RAM is not cleared.
`timescale 1ns / 1ps
module piecewise_linear_tone_curve_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pltc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pltc_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i
);

  pltc_pkg::cfg_t      cfg_q;
  logic                res_valid, res_ready;
  pltc_pkg::out_word_t res_data;
  logic                out_valid_q;
  pltc_pkg::out_word_t out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count <= 6'd7;
      cfg_q.invert      <= 1'b0;
      cfg_q.sample_mode <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pltc_pkg::CfgPointCount: cfg_q.point_count <= cfg_data_i;
        pltc_pkg::CfgInvert:     cfg_q.invert      <= cfg_data_i[0];
        pltc_pkg::CfgSampleMode: cfg_q.sample_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pltc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/pltc_ram.sv =====
// Generic single-port-write, registered-read breakpoint RAM.
`timescale 1ns / 1ps
module pltc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/pltc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pltc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pltc_pkg::div_req_t req_i,
  output pltc_pkg::div_rsp_t rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [pltc_pkg::DivCntW-1:0]      cnt_q;
  logic [pltc_pkg::DenW-1:0]         rem_q;
  logic [pltc_pkg::DenW-1:0]         rem_d;
  logic [pltc_pkg::DenW-1:0]         den_q;
  logic [pltc_pkg::QuoW-1:0]         num_q;
  logic [pltc_pkg::QuoW-1:0]         quo_q;
  logic [pltc_pkg::DenW:0]           shifted;
  logic                              ge;

  always_comb begin
    shifted = {rem_q, num_q[pltc_pkg::QuoW-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? pltc_pkg::DenW'(shifted - {1'b0, den_q}) : pltc_pkg::DenW'(shifted);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + pltc_pkg::DivCntW'(1);
        if (cnt_q == pltc_pkg::DivCntW'(pltc_pkg::QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= pltc_pkg::DenW'(req_i.num[pltc_pkg::NumW-1:pltc_pkg::QuoW]);
      num_q <= req_i.num[pltc_pkg::QuoW-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[pltc_pkg::QuoW-2:0], 1'b0};
      quo_q <= {quo_q[pltc_pkg::QuoW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  `PLTC_ASSERT(a_start_idle, !req_i.start || !busy_q)
  `PLTC_ASSERT_NEXT(a_done_after_busy, done_q, !busy_q && !done_q)

endmodule

// ===== src/pltc_seq.sv =====
// Sequencer and datapath: breakpoint search, shared multiplier, divider control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pltc_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pltc_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pltc_pkg::in_word_t  in_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pltc_pkg::out_word_t res_data_o
);

  pltc_pkg::seq_state_e state_q, state_d;

  logic                       wr_en;
  logic [pltc_pkg::AddrW-1:0] wr_addr;
  logic [31:0]                wr_data;
  logic [pltc_pkg::AddrW-1:0] rd_addr;
  logic [31:0]                rd_data;
  logic [15:0]                rx, ry;

  logic [pltc_pkg::CntW-1:0]  n;
  logic [pltc_pkg::AddrW-1:0] n_m1;
  logic [15:0]                in_v;

  logic [15:0]                ld_x_q, ld_y_q;
  logic [4:0]                 ld_idx_q;
  logic                       ld_ok_q, ld_prev_q;

  logic [15:0]                v_q, ylast_q, prev_x_q, prev_y_q;
  logic [pltc_pkg::AddrW-1:0] j_q;
  logic [15:0]                yl_q, yr_q, d_q, t_q, res_q;
  logic [5:0]                 seg_q;
  logic [31:0]                acc_q, prod_q;

  logic                       upper_hit, lower_hit, found_hit, scan_end;
  logic [15:0]                mul_a, mul_b;
  logic [31:0]                prod;
  logic [32:0]                tot;
  logic [24:0]                den;
  logic [15:0]                fs, clamped;

  pltc_pkg::div_req_t         div_req;
  pltc_pkg::div_rsp_t         div_rsp;

  pltc_ram #(
    .Width(32),
    .Depth(pltc_pkg::MaxPoints)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  pltc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    rx = rd_data[31:16];
    ry = rd_data[15:0];
    if (cfg_i.point_count == 6'd0) begin
      n = pltc_pkg::CntW'(1);
    end else if (int'(cfg_i.point_count) > pltc_pkg::MaxPoints) begin
      n = pltc_pkg::CntW'(pltc_pkg::MaxPoints);
    end else begin
      n = pltc_pkg::CntW'(cfg_i.point_count);
    end
    n_m1 = pltc_pkg::AddrW'(n - pltc_pkg::CntW'(1));
    in_v = cfg_i.sample_mode ? in_data_i.pixel : {in_data_i.pixel[7:0], in_data_i.pixel[7:0]};

    upper_hit = v_q > rx;
    lower_hit = v_q < rx;
    found_hit = (prev_x_q <= v_q) && (v_q < rx);
    scan_end  = j_q == n_m1;

    mul_a = (state_q == pltc_pkg::SMul0) ? yl_q : yr_q;
    mul_b = (state_q == pltc_pkg::SMul0) ? (d_q - t_q) : t_q;
    prod  = mul_a * mul_b;

    tot = {1'b0, acc_q} + {1'b0, prod_q};
    den = cfg_i.sample_mode ? {9'd0, d_q} : ({1'b0, d_q, 8'd0} + {9'd0, d_q});
    div_req.start = state_q == pltc_pkg::SSum;
    div_req.num   = {tot, 1'b0} + pltc_pkg::NumW'(den);
    div_req.den   = {den, 1'b0};

    fs      = cfg_i.sample_mode ? 16'hFFFF : 16'h00FF;
    clamped = (div_rsp.quo > {1'b0, fs}) ? fs : div_rsp.quo[15:0];

    wr_addr = pltc_pkg::AddrW'(ld_idx_q);
    wr_data = {(ld_prev_q && (ld_x_q < rx)) ? rx : ld_x_q, ld_y_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pltc_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    wr_en       = 1'b0;
    rd_addr     = '0;
    res_valid_o = 1'b0;
    unique case (state_q)
      pltc_pkg::SIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.op == pltc_pkg::OpMap) begin
            rd_addr = n_m1;
            state_d = pltc_pkg::SPxLast;
          end else begin
            rd_addr = pltc_pkg::AddrW'(in_data_i.point_index - 5'd1);
            state_d = pltc_pkg::SLdWrite;
          end
        end
      end
      pltc_pkg::SLdWrite: begin
        wr_en   = ld_ok_q;
        state_d = pltc_pkg::SIdle;
      end
      pltc_pkg::SPxLast: begin
        if (upper_hit) begin
          state_d = pltc_pkg::SMul0;
        end else begin
          rd_addr = '0;
          state_d = pltc_pkg::SPxFirst;
        end
      end
      pltc_pkg::SPxFirst: begin
        if (lower_hit || n_m1 == '0) begin
          state_d = pltc_pkg::SMul0;
        end else begin
          rd_addr = pltc_pkg::AddrW'(1);
          state_d = pltc_pkg::SScan;
        end
      end
      pltc_pkg::SScan: begin
        if (found_hit || scan_end) begin
          state_d = pltc_pkg::SMul0;
        end else begin
          rd_addr = j_q + pltc_pkg::AddrW'(1);
        end
      end
      pltc_pkg::SMul0: state_d = pltc_pkg::SMul1;
      pltc_pkg::SMul1: state_d = pltc_pkg::SSum;
      pltc_pkg::SSum:  state_d = pltc_pkg::SDivWait;
      pltc_pkg::SDivWait: begin
        if (div_rsp.done) begin
          state_d = pltc_pkg::SDone;
        end
      end
      pltc_pkg::SDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = pltc_pkg::SIdle;
        end
      end
      default: state_d = pltc_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pltc_pkg::SIdle: begin
        v_q       <= in_v;
        ld_x_q    <= in_data_i.point_x;
        ld_y_q    <= in_data_i.point_y;
        ld_idx_q  <= in_data_i.point_index;
        ld_ok_q   <= int'(in_data_i.point_index) < pltc_pkg::MaxPoints;
        ld_prev_q <= in_data_i.point_index != 5'd0;
      end
      pltc_pkg::SPxLast: begin
        ylast_q <= ry;
        if (upper_hit) begin
          yl_q  <= ry;
          yr_q  <= 16'hFFFF;
          d_q   <= 16'hFFFF - rx;
          t_q   <= v_q - rx;
          seg_q <= 6'(n);
        end
      end
      pltc_pkg::SPxFirst: begin
        prev_x_q <= rx;
        prev_y_q <= ry;
        j_q      <= pltc_pkg::AddrW'(1);
        if (lower_hit) begin
          yl_q  <= '0;
          yr_q  <= ry;
          d_q   <= rx;
          t_q   <= v_q;
          seg_q <= '0;
        end else begin
          yl_q  <= ylast_q;
          yr_q  <= ylast_q;
          d_q   <= 16'd1;
          t_q   <= '0;
          seg_q <= 6'(n_m1);
        end
      end
      pltc_pkg::SScan: begin
        prev_x_q <= rx;
        prev_y_q <= ry;
        j_q      <= j_q + pltc_pkg::AddrW'(1);
        if (found_hit) begin
          yl_q  <= prev_y_q;
          yr_q  <= ry;
          d_q   <= rx - prev_x_q;
          t_q   <= v_q - prev_x_q;
          seg_q <= 6'(j_q);
        end else if (scan_end) begin
          yl_q  <= ylast_q;
          yr_q  <= ylast_q;
          d_q   <= 16'd1;
          t_q   <= '0;
          seg_q <= 6'(n_m1);
        end
      end
      pltc_pkg::SMul0: acc_q <= prod;
      pltc_pkg::SMul1: prod_q <= prod;
      pltc_pkg::SDivWait: begin
        if (div_rsp.done) begin
          res_q <= clamped ^ (cfg_i.invert ? fs : 16'd0);
        end
      end
      default: ;
    endcase
  end

  assign res_data_o.mapped_pixel = res_q;
  assign res_data_o.segment      = seg_q;

  `PLTC_ASSERT(a_t_within_d, state_q != pltc_pkg::SMul0 || (t_q <= d_q && d_q != 16'd0))
  `PLTC_ASSERT(a_scan_index, state_q != pltc_pkg::SScan || (j_q != '0 && j_q <= n_m1))

endmodule
